// ===== rtl/gww_pkg.sv =====
// Package for the greedy word wrap block.
// Types, character codes and widths shared by gww_ring and greedy_word_wrap_top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

    localparam int GWW_MAX_WIDTH = 64;
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 7;

    localparam logic [CNT_W-1:0]  NO_SPACE    = 7'h7F;
    localparam logic [CNT_W-1:0]  WIDTH_RESET = 7'd64;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FIN
    } t_state;

endpackage : gww_pkg

`default_nettype wire

// ===== rtl/greedy_word_wrap_top.sv =====
// Greedy word wrap top level: control, line state and output stage; uses gww_pkg, gww_ring.
// A plain character is written to the ring on acceptance. An item that ends a line of n chars
// goes through emit (one ring read per char) and a finishing state, an empty line with no read;
// output stalls lengthen this. Output drains one beat a cycle while m_axis_tready is high.
// Reset (synchronous, active low) clears the line state and sets the width to 64; the ring
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_top #(
    parameter int MAX_WIDTH = gww_pkg::GWW_MAX_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [gww_pkg::CNT_W-1:0]   i_cfg_wdata,   // line_width
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [gww_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] ch
    input  wire logic                        s_axis_tuser,  // [0] kind
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [gww_pkg::CHAR_W-1:0]  m_axis_tdata,  // [7:0] out_char
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser   // [0] empty_line
);
    import gww_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CNT_W-1:0] MaxW = CNT_W'(MAX_WIDTH);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_width, n_width;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [AW-1:0]     r_start, n_start;
    logic [CNT_W-1:0]  r_ls, n_ls;

    logic [AW-1:0]     r_base, n_base;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_wr_pend, n_wr_pend;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [CHAR_W-1:0] r_wr_data, n_wr_data;

    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_pend_empty, n_pend_empty;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              r_out_empty, n_out_empty;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [CHAR_W-1:0] wdata, rdata;

    logic              accept, move, slot_free;
    logic [CNT_W-1:0]  w;
    logic              do_emit, do_clear, do_cut, do_app;
    logic [CNT_W-1:0]  emit_len, fill_p, ls_p;
    logic [AW-1:0]     start_p;

    gww_ring #(
        .AW(AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign move          = r_pend && (!r_out_valid || m_axis_tready);
    assign slot_free     = !r_pend || move;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_empty;

    always_comb begin
        if (r_width == '0) begin
            w = CNT_W'(1);
        end else if (r_width > MaxW) begin
            w = MaxW;
        end else begin
            w = r_width;
        end
    end

    // line decision for the beat on the input
    always_comb begin
        do_emit  = 1'b0;
        do_clear = 1'b0;
        do_cut   = 1'b0;
        do_app   = 1'b0;
        emit_len = r_fill;
        if (s_axis_tuser == KIND_EOT) begin
            do_emit  = (r_fill != '0);
            do_clear = (r_fill != '0);
        end else if (s_axis_tdata == CH_NL) begin
            do_emit  = 1'b1;
            do_clear = 1'b1;
        end else if (r_fill >= w) begin
            do_emit = 1'b1;
            if (s_axis_tdata == CH_SPACE) begin
                do_clear = 1'b1;
            end else if (r_ls != NO_SPACE && r_ls < r_fill) begin
                do_cut   = 1'b1;
                do_app   = 1'b1;
                emit_len = r_ls;
            end else begin
                do_clear = 1'b1;
                do_app   = 1'b1;
            end
        end else begin
            do_app = 1'b1;
        end

        priority if (do_clear) begin
            start_p = '0;
            fill_p  = '0;
            ls_p    = NO_SPACE;
        end else if (do_cut) begin
            start_p = r_start + r_ls[AW-1:0] + AW'(1);
            fill_p  = r_fill - r_ls - CNT_W'(1);
            ls_p    = NO_SPACE;
        end else begin
            start_p = r_start;
            fill_p  = r_fill;
            ls_p    = r_ls;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_width      = r_width;
        n_fill       = r_fill;
        n_start      = r_start;
        n_ls         = r_ls;
        n_base       = r_base;
        n_len        = r_len;
        n_k          = r_k;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_pend       = r_pend;
        n_pend_last  = r_pend_last;
        n_pend_empty = r_pend_empty;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        we           = 1'b0;
        waddr        = start_p + fill_p[AW-1:0];
        wdata        = s_axis_tdata;
        re           = 1'b0;
        raddr        = r_base + r_k[AW-1:0];

        if (move) begin
            n_out_valid = 1'b1;
            n_out_data  = r_pend_empty ? CH_NUL : rdata;
            n_out_last  = r_pend_last;
            n_out_empty = r_pend_empty;
            n_pend      = 1'b0;
        end else if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_start = start_p;
                    n_fill  = fill_p;
                    n_ls    = ls_p;
                    if (do_app) begin
                        n_fill = fill_p + CNT_W'(1);
                        if (s_axis_tdata == CH_SPACE) begin
                            n_ls = fill_p;
                        end
                    end
                    if (do_emit) begin
                        n_state   = ST_EMIT;
                        n_base    = r_start;
                        n_len     = emit_len;
                        n_k       = '0;
                        n_wr_pend = do_app;
                        n_wr_addr = waddr;
                        n_wr_data = s_axis_tdata;
                    end else begin
                        we = do_app;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_pend = 1'b1;
                    if (r_len == '0) begin
                        n_pend_empty = 1'b1;
                        n_pend_last  = 1'b1;
                        n_state      = ST_FIN;
                    end else begin
                        re           = 1'b1;
                        n_pend_empty = 1'b0;
                        n_pend_last  = (r_k + CNT_W'(1) == r_len);
                        n_k          = r_k + CNT_W'(1);
                        if (r_k + CNT_W'(1) == r_len) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                // carried char goes in only after the old line has been read
                we        = r_wr_pend;
                waddr     = r_wr_addr;
                wdata     = r_wr_data;
                n_wr_pend = 1'b0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_width = i_cfg_wdata;
            n_fill  = '0;
            n_start = '0;
            n_ls    = NO_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= WIDTH_RESET;
            r_fill      <= '0;
            r_start     <= '0;
            r_ls        <= NO_SPACE;
            r_wr_pend   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_fill      <= n_fill;
            r_start     <= n_start;
            r_ls        <= n_ls;
            r_wr_pend   <= n_wr_pend;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_len        <= n_len;
        r_k          <= n_k;
        r_wr_addr    <= n_wr_addr;
        r_wr_data    <= n_wr_data;
        r_pend_last  <= n_pend_last;
        r_pend_empty <= n_pend_empty;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    a_read_in_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> (r_state == ST_EMIT))
        else $error("ring read outside emit");

    a_no_rw_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(re && we))
        else $error("ring read and write in one cycle");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MaxW)
        else $error("fill count above maximum width");

    a_space_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ls != NO_SPACE) |-> (r_ls < r_fill))
        else $error("recorded space outside the buffered line");

    a_fin_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> $past(r_state == ST_EMIT))
        else $error("finish cycle without emit");

endmodule : greedy_word_wrap_top

`default_nettype wire

// ===== rtl/gww_ring.sv =====
// Ring store for the partial line: one write port, one registered read port.
// Depends on gww_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gww_ring #(
    parameter int AW = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [gww_pkg::CHAR_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [gww_pkg::CHAR_W-1:0] o_rdata
);
    import gww_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [CHAR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : gww_ring

`default_nettype wire

// ===== verif/greedy_word_wrap_top_tb.sv =====
// Self-checking testbench for greedy_word_wrap_top: streams text beats, predicts the
// wrapped lines beat by beat and checks every output beat with random idling on both sides.
// Depends on gww_pkg and greedy_word_wrap_top.
`timescale 1ns / 1ps

module greedy_word_wrap_top_tb;
    import gww_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT      = 36;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 14;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
    } t_text_item;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eol;
        logic              blank;
    } t_line_beat;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = KIND_CHAR;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CHAR_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    greedy_word_wrap_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // line predictor state
    logic [CHAR_W-1:0] ring_q [GWW_MAX_WIDTH];
    int                fill_q;
    int                head_q;
    int                space_q;
    int                width_q;

    t_text_item        text_q[$];
    t_line_beat        line_beats_q[$];

    bit                in_taken   = 1'b0;
    bit                burst_mode = 1'b0;
    int                errors     = 0;
    int                cycle_cnt  = 0;
    int                text_beats = 0;
    int                out_beats  = 0;
    int                lines_seen = 0;
    int                blank_seen = 0;
    int                widths_set = 0;

    logic [CNT_W-1:0]  phase_width [NUM_PHASES] =
        '{7'd127, 7'd6, 7'd64, 7'd1, 7'd11, 7'd2, 7'd20, 7'd100, 7'd4, 7'd30};

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int wrap_width();
        int w;
        w = width_q;
        if (w < 1) w = 1;
        if (w > GWW_MAX_WIDTH) w = GWW_MAX_WIDTH;
        return w;
    endfunction

    function automatic void clear_line();
        fill_q  = 0;
        head_q  = 0;
        space_q = int'(NO_SPACE);
    endfunction

    function automatic void queue_line(input int len);
        t_line_beat b;
        int         k;
        if (len == 0) begin
            b.ch    = CH_NUL;
            b.eol   = 1'b1;
            b.blank = 1'b1;
            line_beats_q.push_back(b);
            return;
        end
        for (k = 0; k < len; k++) begin
            b.ch    = ring_q[(head_q + k) % GWW_MAX_WIDTH];
            b.eol   = (k == len - 1);
            b.blank = 1'b0;
            line_beats_q.push_back(b);
        end
    endfunction

    function automatic void take_char(input logic [CHAR_W-1:0] c);
        ring_q[(head_q + fill_q) % GWW_MAX_WIDTH] = c;
        if (c == CH_SPACE) space_q = fill_q;
        fill_q++;
    endfunction

    function automatic void wrap_item(input t_text_item it);
        int w;
        w = wrap_width();
        if (it.kind == KIND_EOT) begin
            if (fill_q > 0) begin
                queue_line(fill_q);
                clear_line();
            end
        end else if (it.ch == CH_NL) begin
            queue_line(fill_q);
            clear_line();
        end else if (fill_q >= w) begin
            if (it.ch == CH_SPACE) begin
                queue_line(fill_q);
                clear_line();
            end else begin
                if (space_q != int'(NO_SPACE) && space_q < fill_q) begin
                    queue_line(space_q);
                    head_q  = (head_q + space_q + 1) % GWW_MAX_WIDTH;
                    fill_q  = fill_q - (space_q + 1);
                    space_q = int'(NO_SPACE);
                end else begin
                    queue_line(fill_q);
                    clear_line();
                end
                take_char(it.ch);
            end
        end else begin
            take_char(it.ch);
        end
    endfunction

    // monitor and checker
    always @(posedge i_clk) begin
        t_line_beat want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            clear_line();
            width_q = int'(WIDTH_RESET);
            line_beats_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                out_beats++;
                if (line_beats_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected beat: char %02h last %b empty %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = line_beats_q.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.eol ||
                        m_axis_tuser !== want.blank) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("mismatch: exp %02h %b %b, got %02h %b %b",
                                     want.ch, want.eol, want.blank,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                    if (want.eol) lines_seen++;
                    if (want.blank) blank_seen++;
                end
            end
            if (i_cfg_we) begin
                width_q = int'(i_cfg_wdata);
                clear_line();
            end
            if (in_taken) begin
                text_beats++;
                wrap_item('{kind: s_axis_tuser, ch: s_axis_tdata});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("greedy_word_wrap_top_tb: FAIL");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_text_item nxt;
        bit         load;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            load = text_q.size() > 0 && (burst_mode || $urandom_range(0, 99) >= IDLE_PCT);
            if (load) begin
                nxt = text_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.ch;
                s_axis_tuser  <= nxt.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic push_char(input logic [CHAR_W-1:0] c);
        t_text_item it;
        it.kind = KIND_CHAR;
        it.ch   = c;
        text_q.push_back(it);
    endtask

    task automatic push_eot();
        t_text_item it;
        it.kind = KIND_EOT;
        it.ch   = CHAR_W'($urandom_range(0, 255));
        text_q.push_back(it);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    // words of random letters split by spaces, newlines and end-of-text items, with some raw noise
    task automatic push_random(input int n, input int w);
        t_text_item it;
        int         word_left;
        int         r;
        word_left = $urandom_range(1, w + 3);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                it.kind = 1'($urandom_range(0, 1));
                it.ch   = CHAR_W'($urandom_range(0, 255));
                text_q.push_back(it);
            end else if (r < 14) begin
                push_eot();
            end else if (r < 20) begin
                push_char(CH_NL);
                word_left = $urandom_range(1, w + 3);
            end else if (word_left == 0) begin
                push_char(CH_SPACE);
                word_left = $urandom_range(0, w + 3);
            end else begin
                push_char(CHAR_W'(8'h61 + $urandom_range(0, 25)));
                word_left--;
            end
        end
    endtask

    task automatic drain();
        while (text_q.size() > 0 || s_axis_tvalid || line_beats_q.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic set_width(input logic [CNT_W-1:0] w);
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_wdata = w;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        widths_set++;
    endtask

    initial begin
        int p;
        int w;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset width: empty line, flush of nothing, byte extremes, flush
        push_char(CH_NL);
        push_eot();
        push_char(8'h00);
        push_char(8'hFF);
        push_text("a");
        push_eot();
        push_text("xy");
        // width write drops the partial line
        set_width(7'd3);
        // leading space break, hard break, space at full line, empty line
        push_text(" abcdef \n");
        push_eot();
        push_text("q");
        set_width(7'd0);
        push_text("ab\n");

        for (p = 0; p < NUM_PHASES; p++) begin
            set_width(p == 6 ? 7'($urandom_range(1, GWW_MAX_WIDTH)) : phase_width[p]);
            w = wrap_width();
            burst_mode = (p == 2);
            if (p == 4) begin
                push_random(PHASE_ITEMS / 2, w);
                drain();
                push_random(PHASE_ITEMS - PHASE_ITEMS / 2, w);
            end else begin
                push_random(PHASE_ITEMS, w);
            end
            push_eot();
            drain();
            burst_mode = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (line_beats_q.size() != 0) errors++;
        $display("run: %0d text beats over %0d width settings, %0d output beats checked",
                 text_beats, widths_set, out_beats);
        $display("     %0d lines of which %0d empty, %0d errors", lines_seen, blank_seen, errors);
        if (errors == 0)
            $display("greedy_word_wrap_top_tb: PASS");
        else
            $display("greedy_word_wrap_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== greedy_word_wrap_top.f =====
rtl/gww_pkg.sv
rtl/gww_ring.sv
rtl/greedy_word_wrap_top.sv
verif/greedy_word_wrap_top_tb.sv
